@@ design/smt_pkg.sv @@
// ----------------------------------------------------------------------------
// smt_pkg
// Shared widths, register indexes and controller/datapath interface structs
// for the sparse matrix transpose core.
// ----------------------------------------------------------------------------
package smt_pkg;

  // triple store depth and field widths
  localparam int unsigned MAX_NONZERO = 63;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned DIM_W       = 8;
  localparam int unsigned VAL_W       = 16;
  localparam int unsigned TRIPLE_W    = 2 * DIM_W + VAL_W;
  localparam int unsigned TDATA_W     = 2 * DIM_W + VAL_W;
  localparam int unsigned TUSER_W     = 2;
  localparam int unsigned CFG_IDX_W   = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;          // take one element word
    logic hdr_load;      // put header in output register, start scan
    logic rd_issue;      // read store at scan index
    logic emit;          // put read triple in output register
    logic scan_step;     // move on to next store entry
    logic pass_restart;  // end of pass, go to next column
    logic clr_run;       // clear run state after emission
  } smt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic end_of_run;    // current element closes the matrix
    logic out_free;      // output register can take a word
    logic nz_zero;       // no triples stored
    logic rd_match;      // read triple sits in current column
    logic last_entry;    // scan index at last stored triple
    logic emit_last;     // next emitted triple is the final one
  } smt_sts_t;

endpackage

@@ design/smt_ctrl.sv @@
// ----------------------------------------------------------------------------
// smt_ctrl
// Controller state machine: load phase, header, column scan passes over the
// triple store and end-of-run clearing.
// ----------------------------------------------------------------------------
module smt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  smt_pkg::smt_sts_t sts_i,
  output smt_pkg::smt_cmd_t cmd_o
);
  import smt_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_HDR  = 5'b00010,
    S_RD   = 5'b00100,
    S_CHK  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && sts_i.end_of_run) begin
          state_d = S_HDR;
        end
      end
      S_HDR: begin
        if (sts_i.out_free) begin
          cmd_o.hdr_load = 1'b1;
          state_d = sts_i.nz_zero ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.rd_match) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            if (sts_i.emit_last) begin
              state_d = S_DONE;
            end else begin
              cmd_o.scan_step    = 1'b1;
              cmd_o.pass_restart = sts_i.last_entry;
              state_d = S_RD;
            end
          end
        end else begin
          cmd_o.scan_step    = 1'b1;
          cmd_o.pass_restart = sts_i.last_entry;
          state_d = S_RD;
        end
      end
      S_DONE: begin
        cmd_o.clr_run = 1'b1;
        state_d = S_LOAD;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // a triple only goes out when the output register has room
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("triple emitted into a full output register");

  // the closing element always leads to the header
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && sts_i.end_of_run) |=> (state_q == S_HDR))
    else $error("end of run not followed by header");

endmodule

@@ design/smt_datapath.sv @@
// ----------------------------------------------------------------------------
// smt_datapath
// Configuration registers, position counters, triple store, column scan
// registers and the output register.
// ----------------------------------------------------------------------------
module smt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [smt_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic [smt_pkg::VAL_W-1:0]     element_i,
  input  smt_pkg::smt_cmd_t             cmd_i,
  output smt_pkg::smt_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [smt_pkg::TDATA_W-1:0]   out_data_o,
  output logic                          out_hdr_o,
  output logic                          out_ovf_o,
  output logic                          out_last_o
);
  import smt_pkg::*;

  logic [DIM_W-1:0]    rows_q, cols_q;
  logic [DIM_W-1:0]    eff_rows, eff_cols;
  logic [DIM_W-1:0]    row_q, col_q;
  logic                col_wrap, row_wrap;
  logic [CNT_W-1:0]    nz_cnt_q;
  logic                ovf_q;
  logic                wr_en;
  logic [TRIPLE_W-1:0] mem_q [MAX_NONZERO];
  logic [TRIPLE_W-1:0] rd_q;
  logic [DIM_W-1:0]    rd_row, rd_col;
  logic [VAL_W-1:0]    rd_val;
  logic [CNT_W-1:0]    idx_q, emit_cnt_q;
  logic [DIM_W-1:0]    cur_q, nxt_q, cand;
  logic                found_q, take;
  logic                out_valid_q;
  logic [TDATA_W-1:0]  out_data_q;
  logic                out_hdr_q, out_ovf_q, out_last_q;

  // configuration registers, zero acts as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DIM_W'(1);
      cols_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_NUM_ROWS) rows_q <= cfg_data_i;
      if (cfg_idx_i == CFG_NUM_COLS) cols_q <= cfg_data_i;
    end
  end

  assign eff_rows = (rows_q == '0) ? DIM_W'(1) : rows_q;
  assign eff_cols = (cols_q == '0) ? DIM_W'(1) : cols_q;

  // row-major position counters
  assign col_wrap = ({1'b0, col_q} + (DIM_W+1)'(1)) >= {1'b0, eff_cols};
  assign row_wrap = ({1'b0, row_q} + (DIM_W+1)'(1)) >= {1'b0, eff_rows};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.load) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + DIM_W'(1);
      end else begin
        col_q <= col_q + DIM_W'(1);
      end
    end
  end

  // non-zero count and overflow flag
  assign wr_en = cmd_i.load && (element_i != '0) && (nz_cnt_q != CNT_W'(MAX_NONZERO));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_cnt_q <= '0;
      ovf_q    <= 1'b0;
    end else if (cmd_i.clr_run) begin
      nz_cnt_q <= '0;
      ovf_q    <= 1'b0;
    end else if (cmd_i.load && (element_i != '0)) begin
      if (wr_en) begin
        nz_cnt_q <= nz_cnt_q + CNT_W'(1);
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // triple store, layout {value, col, row}
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[nz_cnt_q] <= {element_i, col_q, row_q};
    end
    if (cmd_i.rd_issue) begin
      rd_q <= mem_q[idx_q];
    end
  end

  assign rd_row = rd_q[DIM_W-1:0];
  assign rd_col = rd_q[2*DIM_W-1:DIM_W];
  assign rd_val = rd_q[TRIPLE_W-1:2*DIM_W];

  // smallest column above the current one seen so far in this pass
  assign take = (rd_col > cur_q) && (!found_q || (rd_col < nxt_q));
  assign cand = take ? rd_col : nxt_q;

  // scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      cur_q      <= '0;
      nxt_q      <= '0;
      found_q    <= 1'b0;
      emit_cnt_q <= '0;
    end else begin
      if (cmd_i.hdr_load) begin
        idx_q   <= '0;
        cur_q   <= '0;
        nxt_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (cmd_i.pass_restart) begin
          idx_q   <= '0;
          cur_q   <= cand;
          found_q <= 1'b0;
        end else begin
          idx_q   <= idx_q + CNT_W'(1);
          nxt_q   <= cand;
          found_q <= found_q | take;
        end
      end
      if (cmd_i.hdr_load || cmd_i.clr_run) begin
        emit_cnt_q <= '0;
      end else if (cmd_i.emit) begin
        emit_cnt_q <= emit_cnt_q + CNT_W'(1);
      end
    end
  end

  // output register, control part
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.hdr_load || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register, payload part
  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_load) begin
      out_data_q <= {VAL_W'(nz_cnt_q), eff_rows, eff_cols};
      out_hdr_q  <= 1'b1;
      out_ovf_q  <= ovf_q;
      out_last_q <= (nz_cnt_q == '0);
    end else if (cmd_i.emit) begin
      out_data_q <= {rd_val, rd_row, rd_col};
      out_hdr_q  <= 1'b0;
      out_ovf_q  <= ovf_q;
      out_last_q <= sts_o.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_hdr_o   = out_hdr_q;
  assign out_ovf_o   = out_ovf_q;
  assign out_last_o  = out_last_q;

  // status to controller
  always_comb begin
    sts_o            = '0;
    sts_o.end_of_run = col_wrap && row_wrap;
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.nz_zero    = (nz_cnt_q == '0);
    sts_o.rd_match   = (rd_col == cur_q);
    sts_o.last_entry = ({1'b0, idx_q} + (CNT_W+1)'(1)) == {1'b0, nz_cnt_q};
    sts_o.emit_last  = ({1'b0, emit_cnt_q} + (CNT_W+1)'(1)) == {1'b0, nz_cnt_q};
  end

  // overflow only once the store is full
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (nz_cnt_q == CNT_W'(MAX_NONZERO)))
    else $error("overflow flagged with room left in the store");

  // never more triples sent than stored
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_cnt_q <= nz_cnt_q)
    else $error("emitted more triples than stored");

endmodule

@@ design/sparse_matrix_transpose_core.sv @@
// ----------------------------------------------------------------------------
// sparse_matrix_transpose_core
// Dense matrix in, transposed three-tuple (triplet) form out.
// ----------------------------------------------------------------------------
// Elements are taken one word per cycle in row-major order while the block
// loads; each non-zero goes into a 63-entry triple store, further non-zeros
// are dropped and flagged as overflow. The word that closes the matrix
// starts the emission, during which no element is taken: one header word
// (columns, rows, non-zero count), then the triples with row and column
// swapped, ordered by old column then old row. Emission scans the store
// once per distinct column, plus a first pass for column zero when that
// column holds no triple, reading each stored triple in a read state and
// checking it in a check state through the single store read port; a
// stall on the output side holds the emission.
module sparse_matrix_transpose_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [smt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [smt_pkg::DIM_W-1:0]     cfg_data_i,
  // element stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [smt_pkg::VAL_W-1:0]     s_axis_tdata,   // [15:0] element
  // transposed triple stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [smt_pkg::TDATA_W-1:0]   m_axis_tdata,   // [7:0] out_row, [15:8] out_col,
                                                        // [31:16] out_value
  output logic [smt_pkg::TUSER_W-1:0]   m_axis_tuser,   // [0] is_header, [1] overflow
  output logic                          m_axis_tlast    // last_result
);
  import smt_pkg::*;

  smt_cmd_t cmd;
  smt_sts_t sts;
  logic     out_hdr, out_ovf;

  // controller
  smt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  smt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .element_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_hdr_o   (out_hdr),
    .out_ovf_o   (out_ovf),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = {out_ovf, out_hdr};

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sparse matrix transpose core: dense element
// words go in through a queue-fed driver, and a scoreboard predicts the
// transposed triplet stream (header word, then triples sorted by old column
// and old row). A monitor compares every output word field by field.
// Dimensions are rewritten between phases, mid-run included, with random
// idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT      = 9;
  localparam int RANDOM_ITEMS  = 480;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 20_000_000;

  typedef enum int {PH_SMALL, PH_FULL_STORE, PH_EDGE_DIMS, PH_RESHAPE} phase_kind_e;

  // one transposed output word as the block should present it
  typedef struct packed {
    logic [7:0]  new_row;
    logic [7:0]  new_col;
    logic [15:0] value;
    logic        header;
    logic        overflow;
    logic        last_word;
  } transposed_word_t;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          cfg_we_i       = 1'b0;
  logic [smt_pkg::CFG_IDX_W-1:0] cfg_idx_i      = '0;
  logic [smt_pkg::DIM_W-1:0]     cfg_data_i     = '0;
  logic                          s_axis_tvalid  = 1'b0;
  logic                          s_axis_tready;
  logic [smt_pkg::VAL_W-1:0]     s_axis_tdata   = '0;  // [15:0] element
  logic                          m_axis_tvalid;
  logic                          m_axis_tready  = 1'b0;
  logic [smt_pkg::TDATA_W-1:0]   m_axis_tdata;         // [7:0] out_row, [15:8] out_col,
                                                       // [31:16] out_value
  logic [smt_pkg::TUSER_W-1:0]   m_axis_tuser;         // [0] is_header, [1] overflow
  logic                          m_axis_tlast;         // last_result

  sparse_matrix_transpose_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // stimulus and scoreboard state
  logic [15:0]      element_queue[$];
  transposed_word_t expected_words[$];
  transposed_word_t oldest_word;
  int               items_enqueued = 0;
  int               items_accepted = 0;
  int               error_count    = 0;
  int               cycle_count    = 0;
  logic             calm           = 1'b0;

  // shadow of the block: dimensions, counters and triple store
  int          dim_rows = 1;
  int          dim_cols = 1;
  int          row_cnt  = 0;
  int          col_cnt  = 0;
  int          nz_count = 0;
  logic        ovf_seen = 1'b0;
  logic [7:0]  kept_row [smt_pkg::MAX_NONZERO];
  logic [7:0]  kept_col [smt_pkg::MAX_NONZERO];
  logic [15:0] kept_val [smt_pkg::MAX_NONZERO];

  initial forever #5 clk_i = ~clk_i;

  // load one element and, if it closes the matrix, queue the transpose
  task automatic predict_transpose(input logic [15:0] element);
    transposed_word_t w;
    int emitted;
    if (element != 16'h0000) begin
      if (nz_count < smt_pkg::MAX_NONZERO) begin
        kept_row[nz_count] = 8'(row_cnt);
        kept_col[nz_count] = 8'(col_cnt);
        kept_val[nz_count] = element;
        nz_count++;
      end else begin
        ovf_seen = 1'b1;
      end
    end
    if (col_cnt + 1 >= dim_cols) begin
      col_cnt = 0;
      if (row_cnt + 1 >= dim_rows) begin
        row_cnt        = 0;
        w.new_row      = 8'(dim_cols);
        w.new_col      = 8'(dim_rows);
        w.value        = 16'(nz_count);
        w.header       = 1'b1;
        w.overflow     = ovf_seen;
        w.last_word    = (nz_count == 0);
        expected_words.push_back(w);
        // store is in arrival order, so a column sweep keeps old row order
        emitted = 0;
        for (int c = 0; c < 256; c++) begin
          for (int i = 0; i < nz_count; i++) begin
            if (kept_col[i] == 8'(c)) begin
              emitted++;
              w.new_row   = kept_col[i];
              w.new_col   = kept_row[i];
              w.value     = kept_val[i];
              w.header    = 1'b0;
              w.overflow  = ovf_seen;
              w.last_word = (emitted == nz_count);
              expected_words.push_back(w);
            end
          end
        end
        nz_count = 0;
        ovf_seen = 1'b0;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // element driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_transpose(s_axis_tdata);
        items_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (element_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= element_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // triple monitor and back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word tdata 0x%0h", m_axis_tdata));
        end else begin
          oldest_word = expected_words.pop_front();
          check_field("out_row", 16'(m_axis_tdata[7:0]), 16'(oldest_word.new_row));
          check_field("out_col", 16'(m_axis_tdata[15:8]), 16'(oldest_word.new_col));
          check_field("out_value", m_axis_tdata[31:16], oldest_word.value);
          check_field("is_header", 16'(m_axis_tuser[0]), 16'(oldest_word.header));
          check_field("overflow", 16'(m_axis_tuser[1]), 16'(oldest_word.overflow));
          check_field("last_result", 16'(m_axis_tlast), 16'(oldest_word.last_word));
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_dim(input logic [smt_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    // a zero dimension behaves as one
    if (idx == smt_pkg::CFG_NUM_ROWS) dim_rows = (value == 8'd0) ? 1 : int'(value);
    else dim_cols = (value == 8'd0) ? 1 : int'(value);
  endtask

  task automatic enqueue(input logic [15:0] element);
    element_queue.push_back(element);
    items_enqueued++;
  endtask

  function automatic logic [15:0] pick_element(input int nz_pct);
    logic [15:0] v;
    if ($urandom_range(0, 99) >= nz_pct) return 16'h0000;
    case ($urandom_range(0, 11))
      0:       v = 16'h8000;
      1:       v = 16'h7fff;
      2:       v = 16'hffff;
      3:       v = 16'h0001;
      default: v = 16'($urandom);
    endcase
    return (v == 16'h0000) ? 16'h5a5a : v;
  endfunction

  task automatic fill_elements(input int count, input int nz_pct);
    for (int i = 0; i < count; i++) enqueue(pick_element(nz_pct));
  endtask

  // wait until every word is accepted and every triple has arrived
  task automatic settle();
    while (items_accepted != items_enqueued || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    phase_kind_e kind;
    int          phase_no;
    int          random_target;
    int          n;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset dimensions are 1x1: every element closes a matrix
    enqueue(16'h0000);
    enqueue(16'h7fff);
    enqueue(16'h8000);
    enqueue(16'hffff);
    enqueue(16'h0001);
    settle();

    // zero dimensions behave as one
    write_dim(smt_pkg::CFG_NUM_ROWS, 8'd0);
    write_dim(smt_pkg::CFG_NUM_COLS, 8'd0);
    enqueue(16'h1234);
    settle();

    // small 2x3 matrix with zeros mixed in
    write_dim(smt_pkg::CFG_NUM_ROWS, 8'd2);
    write_dim(smt_pkg::CFG_NUM_COLS, 8'd3);
    enqueue(16'h0000);
    enqueue(16'h0005);
    enqueue(16'h0000);
    enqueue(16'h8000);
    enqueue(16'h0000);
    enqueue(16'h7fff);
    settle();

    // largest dimensions, then shrink mid-run: column wrap, then row end
    write_dim(smt_pkg::CFG_NUM_ROWS, 8'd255);
    write_dim(smt_pkg::CFG_NUM_COLS, 8'd255);
    enqueue(16'h0011);
    enqueue(16'h0000);
    enqueue(16'h0033);
    settle();
    write_dim(smt_pkg::CFG_NUM_COLS, 8'd2);
    enqueue(16'hfff0);
    settle();
    write_dim(smt_pkg::CFG_NUM_ROWS, 8'd1);
    enqueue(16'h0042);
    enqueue(16'h0043);
    settle();

    // random phases, the first one overfills the store
    random_target = items_enqueued + RANDOM_ITEMS;
    phase_no      = 0;
    while (items_enqueued < random_target) begin
      calm <= (phase_no >= 4 && phase_no < 8);
      n = $urandom_range(0, 9);
      if (phase_no == 0)  kind = PH_FULL_STORE;
      else if (n < 6)     kind = PH_SMALL;
      else if (n == 6)    kind = PH_FULL_STORE;
      else if (n == 7)    kind = PH_EDGE_DIMS;
      else                kind = PH_RESHAPE;
      case (kind)
        PH_SMALL: begin
          write_dim(smt_pkg::CFG_NUM_ROWS, 8'($urandom_range(1, 6)));
          write_dim(smt_pkg::CFG_NUM_COLS, 8'($urandom_range(1, 6)));
          fill_elements(dim_rows * dim_cols * $urandom_range(1, 3), $urandom_range(10, 100));
        end
        PH_FULL_STORE: begin
          write_dim(smt_pkg::CFG_NUM_ROWS, 8'($urandom_range(8, 10)));
          write_dim(smt_pkg::CFG_NUM_COLS, 8'($urandom_range(8, 12)));
          fill_elements(dim_rows * dim_cols, (phase_no == 0) ? 100 : $urandom_range(85, 100));
        end
        PH_EDGE_DIMS: begin
          if ($urandom_range(0, 1)) begin
            write_dim(smt_pkg::CFG_NUM_ROWS, 8'($urandom_range(0, 1)));
            write_dim(smt_pkg::CFG_NUM_COLS, 8'($urandom_range(0, 1)));
            fill_elements($urandom_range(3, 10), 50);
          end else begin
            // single row vector: many distinct columns, slowest emission
            write_dim(smt_pkg::CFG_NUM_ROWS, 8'd1);
            write_dim(smt_pkg::CFG_NUM_COLS, 8'($urandom_range(32, 64)));
            fill_elements(dim_cols, 100);
          end
        end
        default: begin
          write_dim(smt_pkg::CFG_NUM_ROWS,
                    $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(2, 254)));
          write_dim(smt_pkg::CFG_NUM_COLS,
                    $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(2, 254)));
          fill_elements($urandom_range(1, 12), $urandom_range(20, 100));
          settle();
          write_dim(smt_pkg::CFG_NUM_ROWS, 8'($urandom_range(1, 4)));
          write_dim(smt_pkg::CFG_NUM_COLS, 8'($urandom_range(1, 4)));
          fill_elements($urandom_range(1, 16), $urandom_range(20, 100));
        end
      endcase
      settle();
      phase_no++;
    end

    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
